FILE: src/cbpc_pkg.sv
// ----------------------------------------------------------------------------
// Checkerboard pixel color package
// Widths, configuration register codes and the data carried down the
// cell index divider pipeline.
// ----------------------------------------------------------------------------
package cbpc_pkg;

  localparam int COORD_BITS    = 16;
  localparam int COLOR_BITS    = 64;
  localparam int LEVEL_BITS    = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COLOR_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CELL_WIDTH    = 3'd0,
    REG_CELL_HEIGHT   = 3'd1,
    REG_GRID_OFFSET_X = 3'd2,
    REG_GRID_OFFSET_Y = 3'd3,
    REG_FIRST_COLOR   = 3'd4,
    REG_SECOND_COLOR  = 3'd5
  } cfg_reg_t;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  localparam coord_t CELL_SIZE_RESET = coord_t'(16);

  typedef struct packed {
    coord_t cell_width;
    coord_t cell_height;
    coord_t grid_offset_x;
    coord_t grid_offset_y;
    color_t first_color;
    color_t second_color;
  } cfg_regs_t;

  // One axis of the restoring divider: the dividend shifts out at the top,
  // the partial remainder stays below the divisor, q is the newest quotient bit.
  typedef struct packed {
    coord_t num;
    coord_t rem;
    coord_t size;
    logic   q;
  } div_lane_t;

  typedef struct packed {
    div_lane_t x;
    div_lane_t y;
    logic      flip;
    logic      last;
  } div_item_t;

  function automatic div_lane_t div_step(input div_lane_t a);
    logic [COORD_BITS:0] trial;
    logic [COORD_BITS:0] diff;
    div_lane_t           r;
    trial  = {a.rem, a.num[COORD_BITS-1]};
    diff   = trial - {1'b0, a.size};
    r      = a;
    r.num  = {a.num[COORD_BITS-2:0], 1'b0};
    if (trial >= {1'b0, a.size}) begin
      r.rem = diff[COORD_BITS-1:0];
      r.q   = 1'b1;
    end else begin
      r.rem = trial[COORD_BITS-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: src/cbpc_if.sv
// ----------------------------------------------------------------------------
// Checkerboard pixel color channels
// Pixel request, color result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface cbpc_in_if
  import cbpc_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [LEVEL_BITS-1:0]        detail_level;
  logic                         last_in;

  modport source (output valid, pixel_x, pixel_y, detail_level, last_in, input ready);
  modport sink   (input valid, pixel_x, pixel_y, detail_level, last_in, output ready);
endinterface

interface cbpc_out_if
  import cbpc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  cell_parity;
  logic                  last_out;

  modport source (output valid, pixel_color, cell_parity, last_out, input ready);
  modport sink   (input valid, pixel_color, cell_parity, last_out, output ready);
endinterface

interface cbpc_cfg_if
  import cbpc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  reg_index;
  logic [CFG_DATA_BITS-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: src/checkerboard_pixel_color_core.sv
// ----------------------------------------------------------------------------
// Checkerboard pixel color core
// Maps a pixel coordinate and detail level to one of two checkerboard colors.
// ----------------------------------------------------------------------------
// Usage:
// A pixel request on in_pix carries pixel_x, pixel_y, detail_level and
// last_in; for each request exactly one result leaves on out_pix with the
// chosen color, the cell parity and the copied last marker, in order.
// Registers are written on cfg_wr (index, data); the port is always ready,
// and writes are meant to happen only while no request is in flight.
// A request passes one front stage for the offset subtract and cell size
// shift, 16 divider stages (one quotient bit of a 16-bit restoring division
// per stage) and the output register on its way to a valid result. One
// request is accepted every cycle while out_pix is ready.
// When the receiver stalls, results back up stage by stage; empty stages
// still fill, so in_pix stays ready until every stage holds a request.
// Reset clears all stage valid bits and loads the register defaults:
// 16 by 16 cells, zero offsets, first color zero, second color all ones.
// ----------------------------------------------------------------------------
module checkerboard_pixel_color_core
  import cbpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cbpc_in_if.sink    in_pix,
  cbpc_out_if.source out_pix,
  cbpc_cfg_if.sink   cfg_wr
);

  cfg_regs_t regs;

  logic      front_valid;
  div_item_t front_item;
  logic      front_ready;
  logic      div_valid;
  div_item_t div_item;
  logic      div_ready;

  logic   out_valid_r;
  logic   out_valid_nxt;
  color_t color_r;
  logic   parity_r;
  logic   last_r;
  logic   parity_nxt;

  cbpc_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .regs  (regs)
  );

  cbpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix      (in_pix),
    .regs     (regs),
    .dn_valid (front_valid),
    .dn_item  (front_item),
    .dn_ready (front_ready)
  );

  cbpc_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_item  (front_item),
    .up_ready (front_ready),
    .dn_valid (div_valid),
    .dn_item  (div_item),
    .dn_ready (div_ready)
  );

  assign div_ready   = !out_valid_r || out_pix.ready;
  assign parity_nxt  = div_item.x.q ^ div_item.y.q ^ div_item.flip;

  assign out_pix.valid       = out_valid_r;
  assign out_pix.pixel_color = color_r;
  assign out_pix.cell_parity = parity_r;
  assign out_pix.last_out    = last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (div_ready) begin
      out_valid_nxt = div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) begin
      color_r  <= parity_nxt ? regs.second_color : regs.first_color;
      parity_r <= parity_nxt;
      last_r   <= div_item.last;
    end
  end

endmodule

FILE: src/cbpc_cfg.sv
// ----------------------------------------------------------------------------
// Checkerboard configuration registers
// Holds cell sizes, grid offsets and the two colors; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cbpc_cfg
  import cbpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  cbpc_cfg_if.sink     cfg,
  output cfg_regs_t    regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg.ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_CELL_WIDTH:    regs_nxt.cell_width    = cfg.wr_data[COORD_BITS-1:0];
        REG_CELL_HEIGHT:   regs_nxt.cell_height   = cfg.wr_data[COORD_BITS-1:0];
        REG_GRID_OFFSET_X: regs_nxt.grid_offset_x = cfg.wr_data[COORD_BITS-1:0];
        REG_GRID_OFFSET_Y: regs_nxt.grid_offset_y = cfg.wr_data[COORD_BITS-1:0];
        REG_FIRST_COLOR:   regs_nxt.first_color   = cfg.wr_data[COLOR_BITS-1:0];
        REG_SECOND_COLOR:  regs_nxt.second_color  = cfg.wr_data[COLOR_BITS-1:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.cell_width    <= CELL_SIZE_RESET;
      regs_r.cell_height   <= CELL_SIZE_RESET;
      regs_r.grid_offset_x <= '0;
      regs_r.grid_offset_y <= '0;
      regs_r.first_color   <= '0;
      regs_r.second_color  <= '1;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

FILE: src/cbpc_front.sv
// ----------------------------------------------------------------------------
// Checkerboard front stage
// Subtracts the grid offset, folds negative distances and derives cell sizes.
// ----------------------------------------------------------------------------
module cbpc_front
  import cbpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cbpc_in_if.sink    pix,
  input  cfg_regs_t  regs,
  output logic       dn_valid,
  output div_item_t  dn_item,
  input  logic       dn_ready
);

  logic      valid_r;
  logic      valid_nxt;
  div_item_t item_r;
  div_item_t item_nxt;

  logic [COORD_BITS:0] dist_x;
  logic [COORD_BITS:0] dist_y;
  logic                neg_x;
  logic                neg_y;
  coord_t              size_x;
  coord_t              size_y;

  assign pix.ready = !valid_r || dn_ready;
  assign dn_valid  = valid_r;
  assign dn_item   = item_r;

  always_comb begin
    dist_x = {pix.pixel_x[COORD_BITS-1], pix.pixel_x}
           - {regs.grid_offset_x[COORD_BITS-1], regs.grid_offset_x};
    dist_y = {pix.pixel_y[COORD_BITS-1], pix.pixel_y}
           - {regs.grid_offset_y[COORD_BITS-1], regs.grid_offset_y};
    neg_x  = dist_x[COORD_BITS];
    neg_y  = dist_y[COORD_BITS];
    size_x = regs.cell_width >> pix.detail_level;
    size_y = regs.cell_height >> pix.detail_level;
    if (size_x == '0) begin
      size_x = coord_t'(1);
    end
    if (size_y == '0) begin
      size_y = coord_t'(1);
    end
    // Floor division of a negative d equals -(~d / s) - 1, whose parity is
    // the parity of ~d / s inverted.
    item_nxt.x.num  = neg_x ? ~dist_x[COORD_BITS-1:0] : dist_x[COORD_BITS-1:0];
    item_nxt.x.rem  = '0;
    item_nxt.x.size = size_x;
    item_nxt.x.q    = 1'b0;
    item_nxt.y.num  = neg_y ? ~dist_y[COORD_BITS-1:0] : dist_y[COORD_BITS-1:0];
    item_nxt.y.rem  = '0;
    item_nxt.y.size = size_y;
    item_nxt.y.q    = 1'b0;
    item_nxt.flip   = neg_x ^ neg_y;
    item_nxt.last   = pix.last_in;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (pix.ready) begin
      valid_nxt = pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.ready && pix.valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: src/cbpc_div_pipe.sv
// ----------------------------------------------------------------------------
// Checkerboard cell index divider
// Pipelined restoring divider, one quotient bit per stage on both axes.
// ----------------------------------------------------------------------------
module cbpc_div_pipe
  import cbpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  div_item_t  up_item,
  output logic       up_ready,
  output logic       dn_valid,
  output div_item_t  dn_item,
  input  logic       dn_ready
);

  localparam int NSTAGES = COORD_BITS;

  logic [NSTAGES-1:0] valid_r;
  logic [NSTAGES-1:0] stage_ready;
  div_item_t          stage_r [NSTAGES];

  assign up_ready = stage_ready[0];
  assign dn_valid = valid_r[NSTAGES-1];
  assign dn_item  = stage_r[NSTAGES-1];

  for (genvar k = 0; k < NSTAGES; k++) begin : g_stage
    logic      in_valid;
    div_item_t in_item;
    div_item_t step_item;
    logic      next_ready;

    if (k == 0) begin : g_first
      assign in_valid = up_valid;
      assign in_item  = up_item;
    end else begin : g_rest
      assign in_valid = valid_r[k-1];
      assign in_item  = stage_r[k-1];
    end

    if (k == NSTAGES - 1) begin : g_last
      assign next_ready = dn_ready;
    end else begin : g_mid
      assign next_ready = stage_ready[k+1];
    end

    // A stage takes a new request when it is empty or its content moves on.
    assign stage_ready[k] = !valid_r[k] || next_ready;

    always_comb begin
      step_item   = in_item;
      step_item.x = div_step(in_item.x);
      step_item.y = div_step(in_item.y);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        valid_r[k] <= in_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_ready[k] && in_valid) begin
        stage_r[k] <= step_item;
      end
    end
  end

endmodule

FILE: test/checkerboard_pixel_color_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checkerboard pixel color core testbench
// Sends pixel requests with random gaps and random result stalls, predicts
// the checkerboard color of every accepted request from its own copy of the
// grid registers, and compares each result in order. The grid registers are
// reprogrammed between phases, only once the pipeline has emptied.
// ----------------------------------------------------------------------------
module checkerboard_pixel_color_core_test;
  import cbpc_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_PIXELS   = 130;
  localparam int PIPE_LATENCY   = 18;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    logic [LEVEL_BITS-1:0] level;
    logic                  last;
  } pix_req_t;

  typedef struct packed {
    color_t color;
    logic   parity;
    logic   last;
  } color_res_t;

  logic clk;
  logic rst_n;

  cbpc_in_if  pix_in_ch();
  cbpc_out_if pix_out_ch();
  cbpc_cfg_if cfg_ch();

  checkerboard_pixel_color_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_in_ch),
    .out_pix (pix_out_ch),
    .cfg_wr  (cfg_ch)
  );

  // Local copy of the grid registers, starting from the reset values.
  coord_t cur_cell_w  = CELL_SIZE_RESET;
  coord_t cur_cell_h  = CELL_SIZE_RESET;
  coord_t cur_off_x   = '0;
  coord_t cur_off_y   = '0;
  color_t cur_color_a = '0;
  color_t cur_color_b = '1;

  pix_req_t   pending_pixels[$];
  color_res_t expected_colors[$];
  pix_req_t   next_pixel;
  int         color_errors = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  logic       pix_accepted = 1'b0;
  bit         no_idle = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic coord_t eff_size(coord_t size, logic [LEVEL_BITS-1:0] lvl);
    coord_t s;
    s = size >> lvl;
    return (s == '0) ? coord_t'(1) : s;
  endfunction

  // Floor division, so coordinates left of or above the origin round down.
  function automatic int floor_cell_index(coord_t c, coord_t off, coord_t size);
    int d;
    int w;
    d = int'($signed(c)) - int'($signed(off));
    w = int'(size);
    if (d >= 0) begin
      return d / w;
    end
    return (d + 1) / w - 1;
  endfunction

  function automatic color_res_t predict_color(pix_req_t p);
    int         ix;
    int         iy;
    color_res_t r;
    ix = floor_cell_index(p.x, cur_off_x, eff_size(cur_cell_w, p.level));
    iy = floor_cell_index(p.y, cur_off_y, eff_size(cur_cell_h, p.level));
    // Low bit of the two's complement sum; negative odd sums pick the second color.
    r.parity = ix[0] ^ iy[0];
    r.color  = r.parity ? cur_color_b : cur_color_a;
    r.last   = p.last;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Request driver: a new request goes out once the previous one was accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!pix_in_ch.valid || pix_accepted) begin
        if (send_gap != 0) begin
          send_gap        <= send_gap - 1;
          pix_in_ch.valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          next_pixel              = pending_pixels.pop_front();
          pix_in_ch.pixel_x      <= next_pixel.x;
          pix_in_ch.pixel_y      <= next_pixel.y;
          pix_in_ch.detail_level <= next_pixel.level;
          pix_in_ch.last_in      <= next_pixel.last;
          pix_in_ch.valid        <= 1'b1;
          send_gap               <= pick_gap();
        end else begin
          pix_in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result stalls.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left       <= stall_left - 1;
      pix_out_ch.ready <= 1'b0;
    end else begin
      pix_out_ch.ready <= 1'b1;
      stall_left       <= pick_gap();
    end
  end

  // Prediction on every accepted request, comparison on every accepted result.
  always @(posedge clk) begin
    pix_accepted <= rst_n && pix_in_ch.valid && pix_in_ch.ready;
    if (rst_n && pix_in_ch.valid && pix_in_ch.ready) begin
      expected_colors.push_back(predict_color('{pix_in_ch.pixel_x, pix_in_ch.pixel_y,
                                                pix_in_ch.detail_level, pix_in_ch.last_in}));
    end
    if (rst_n && pix_out_ch.valid && pix_out_ch.ready) begin
      if (expected_colors.size() == 0) begin
        if (color_errors < 10) begin
          $display("%0t: result with no request pending: color %h parity %b last %b",
                   $realtime, pix_out_ch.pixel_color, pix_out_ch.cell_parity,
                   pix_out_ch.last_out);
        end
        color_errors <= color_errors + 1;
      end else begin
        color_res_t exp_res;
        exp_res = expected_colors.pop_front();
        if (pix_out_ch.pixel_color !== exp_res.color ||
            pix_out_ch.cell_parity !== exp_res.parity ||
            pix_out_ch.last_out !== exp_res.last) begin
          if (color_errors < 10) begin
            $display("%0t: mismatch: color %h/%h parity %b/%b last %b/%b (expected/actual)",
                     $realtime, exp_res.color, pix_out_ch.pixel_color, exp_res.parity,
                     pix_out_ch.cell_parity, exp_res.last, pix_out_ch.last_out);
          end
          color_errors <= color_errors + 1;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, color_t data);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CELL_WIDTH:    cur_cell_w  = data[COORD_BITS-1:0];
      REG_CELL_HEIGHT:   cur_cell_h  = data[COORD_BITS-1:0];
      REG_GRID_OFFSET_X: cur_off_x   = data[COORD_BITS-1:0];
      REG_GRID_OFFSET_Y: cur_off_y   = data[COORD_BITS-1:0];
      REG_FIRST_COLOR:   cur_color_a = data;
      REG_SECOND_COLOR:  cur_color_b = data;
      default: ;
    endcase
  endtask

  // Upper data bits of the coordinate registers carry junk that must be dropped.
  task automatic program_grid(coord_t w, coord_t h, coord_t ox, coord_t oy,
                              color_t c1, color_t c2, bit with_spare);
    color_t junk;
    if (with_spare) begin
      write_reg(REG_SPARE_LO, {$urandom, $urandom});
      write_reg(REG_SPARE_HI, {$urandom, $urandom});
    end
    junk = {$urandom, $urandom};
    write_reg(REG_CELL_WIDTH, {junk[COLOR_BITS-1:COORD_BITS], w});
    write_reg(REG_CELL_HEIGHT, {junk[COLOR_BITS-1:COORD_BITS], h});
    write_reg(REG_GRID_OFFSET_X, {junk[COLOR_BITS-1:COORD_BITS], ox});
    write_reg(REG_GRID_OFFSET_Y, {junk[COLOR_BITS-1:COORD_BITS], oy});
    write_reg(REG_FIRST_COLOR, c1);
    write_reg(REG_SECOND_COLOR, c2);
    if (with_spare) begin
      write_reg(REG_SPARE_HI, {$urandom, $urandom});
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_pixel(int x, int y, int lvl, bit last);
    pending_pixels.push_back('{coord_t'(x), coord_t'(y), lvl[LEVEL_BITS-1:0], last});
  endtask

  // Mostly points near the origin and near cell borders, some anywhere.
  task automatic queue_random_pixels(int count);
    pix_req_t p;
    int       pick;
    coord_t   sx;
    coord_t   sy;
    for (int i = 0; i < count; i++) begin
      p.level = ($urandom_range(0, 9) < 7) ? LEVEL_BITS'($urandom_range(0, 3))
                                           : LEVEL_BITS'($urandom_range(0, 15));
      p.last  = 1'($urandom_range(0, 1));
      sx      = eff_size(cur_cell_w, p.level);
      sy      = eff_size(cur_cell_h, p.level);
      pick    = $urandom_range(0, 9);
      if (pick < 3) begin
        p.x = coord_t'($urandom);
        p.y = coord_t'($urandom);
      end else if (pick < 6) begin
        p.x = coord_t'(int'($signed(cur_off_x)) + int'($urandom_range(0, 400)) - 200);
        p.y = coord_t'(int'($signed(cur_off_y)) + int'($urandom_range(0, 400)) - 200);
      end else begin
        p.x = coord_t'(int'($signed(cur_off_x)) + (int'($urandom_range(0, 8)) - 4) * int'(sx)
                       + int'($urandom_range(0, 2)) - 1);
        p.y = coord_t'(int'($signed(cur_off_y)) + (int'($urandom_range(0, 8)) - 4) * int'(sy)
                       + int'($urandom_range(0, 2)) - 1);
      end
      pending_pixels.push_back(p);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_pixels.size() != 0 || pix_in_ch.valid || expected_colors.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    pix_in_ch.valid        = 1'b0;
    pix_in_ch.pixel_x      = '0;
    pix_in_ch.pixel_y      = '0;
    pix_in_ch.detail_level = '0;
    pix_in_ch.last_in      = 1'b0;
    pix_out_ch.ready       = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.reg_index       = REG_CELL_WIDTH;
    cfg_ch.wr_data         = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on the reset grid: 16 by 16 cells at the origin.
    push_pixel(0, 0, 0, 0);
    push_pixel(-1, -1, 0, 0);
    push_pixel(-1, 0, 0, 1);
    push_pixel(15, 0, 0, 0);
    push_pixel(16, 0, 0, 0);
    push_pixel(-16, 0, 0, 1);
    push_pixel(-17, 0, 0, 0);
    push_pixel(-32768, -32768, 0, 1);
    push_pixel(32767, 32767, 0, 0);
    push_pixel(-32768, 32767, 0, 0);
    push_pixel(32767, -32768, 15, 1);
    push_pixel(5, 3, 4, 0);
    push_pixel(5, 3, 5, 0);
    push_pixel(7, -9, 15, 0);
    push_pixel(100, -100, 1, 1);
    push_pixel(-100, 100, 2, 0);
    push_pixel(31, -33, 3, 1);
    wait_for_drain();

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      no_idle = (k == 2 || k == 5);
      case (k)
        0: program_grid(1, 1, 0, 0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        1: program_grid(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, '1, '0, 1'b0);
        // Zero sizes must behave as one pixel cells.
        2: program_grid(0, 0, coord_t'($urandom), coord_t'($urandom), '0, '1, 1'b1);
        3: program_grid(3, 7, coord_t'($urandom), coord_t'($urandom),
                        {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        4: program_grid(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                        coord_t'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        default: program_grid(coord_t'($urandom_range(1, 64)), coord_t'($urandom_range(1, 64)),
                              coord_t'($urandom), coord_t'($urandom),
                              {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      endcase
      queue_random_pixels(PHASE_PIXELS);
      wait_for_drain();
    end

    repeat (PIPE_LATENCY + 12) @(posedge clk);
    if (color_errors == 0 && expected_colors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
